[hw/rtl/mmfa_pkg.sv]
// ----------------------------------------------------------------------------
// mmfa_pkg
// Shared types and codes for the Mueller matrix form and apply core.
// ----------------------------------------------------------------------------
package mmfa_pkg;

    typedef enum logic [1:0] {
        OP_FORM   = 2'd0,
        OP_APPLY  = 2'd1,
        OP_INVERT = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_GENERAL = 2'd0,
        KIND_DIAG    = 2'd1,
        KIND_CORNER  = 2'd2,
        KIND_SCALAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SINGULAR = 2'd1,
        ST_MISMATCH = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  vis_count;
        logic [31:0] op_a0;
        logic [31:0] op_a1;
        logic [31:0] op_a2;
        logic [31:0] op_a3;
        logic [31:0] op_b0;
        logic [31:0] op_b1;
        logic [31:0] op_b2;
        logic [31:0] op_b3;
    } t_req;

    typedef struct packed {
        logic [31:0] out_v0;
        logic [31:0] out_v1;
        logic [31:0] out_v2;
        logic [31:0] out_v3;
        logic [1:0]  status;
    } t_res;

    // Controller to datapath commands.
    typedef struct packed {
        logic       load;
        logic       issue;
        logic       x_store;
        logic [3:0] x_idx;
        logic       y_self;
        logic       y_b;
        logic [1:0] y_idx;
        logic       conj;
        logic       wr_store;
        logic [3:0] st_idx;
        logic       wr_lane;
        logic [1:0] lane;
        logic       first;
        logic       div_go;
        logic       inv_wr;
        logic [1:0] inv_idx;
        logic       clr;
        logic       finish;
        t_status    status;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic sing;
        logic div_done;
    } t_sts;

    // Index of the last store entry used by a kind.
    function automatic logic [3:0] kind_last(input t_kind k);
        logic [3:0] r;
        unique case (k)
            KIND_GENERAL: r = 4'd15;
            KIND_DIAG:    r = 4'd3;
            KIND_CORNER:  r = 4'd1;
            default:      r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/mmfa_div.sv]
// ----------------------------------------------------------------------------
// mmfa_div
// Bit-serial reciprocal unit: conj(m)/|m|^2 for one complex entry, one
// quotient bit per cycle for both parts at once.
// ----------------------------------------------------------------------------
module mmfa_div #(
    parameter int W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic signed [W-1:0] i_m_re,
    input  logic signed [W-1:0] i_m_im,
    input  logic [2*W-1:0]      i_d,
    output logic                o_done,
    output logic signed [W-1:0] o_v_re,
    output logic signed [W-1:0] o_v_im
);
    localparam int S  = 2 * W - 7;
    localparam int NB = W + S;
    localparam int CW = $clog2(NB + 1);
    localparam logic [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};

    logic [CW-1:0]  r_cnt;
    logic           r_fin;
    logic           r_done;
    logic [NB-1:0]  r_n_re, r_n_im;
    logic [2*W:0]   r_r_re, r_r_im;
    logic [W-1:0]   r_q_re, r_q_im;
    logic           r_ov_re, r_ov_im;
    logic [2*W-1:0] r_d;
    logic           r_neg_re, r_neg_im;
    logic signed [W-1:0] r_v_re, r_v_im;

    logic [W-1:0] mag_re, mag_im;
    logic [2*W:0] t_re, t_im;
    logic         ge_re, ge_im;
    logic [W-1:0] fin_re, fin_im;

    function automatic logic [W-1:0] round_half(input logic [W-1:0] q, input logic ov);
        logic [W-1:0] qs;
        logic [W:0]   rr;
        qs = ov ? {W{1'b1}} : q;
        rr = ({1'b0, qs} + (W+1)'(1)) >> 1;
        return rr[W-1] ? CMAX : rr[W-1:0];
    endfunction

    always_comb begin
        mag_re = i_m_re[W-1] ? (~i_m_re + W'(1)) : i_m_re;
        mag_im = i_m_im[W-1] ? (~i_m_im + W'(1)) : i_m_im;
        t_re   = {r_r_re[2*W-1:0], r_n_re[NB-1]};
        t_im   = {r_r_im[2*W-1:0], r_n_im[NB-1]};
        ge_re  = t_re >= {1'b0, r_d};
        ge_im  = t_im >= {1'b0, r_d};
        fin_re = round_half(r_q_re, r_ov_re);
        fin_im = round_half(r_q_im, r_ov_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= (r_cnt == CW'(1));
            if (i_go) begin
                r_cnt <= CW'(NB);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (i_go) begin
            r_n_re   <= {mag_re, {S{1'b0}}};
            r_n_im   <= {mag_im, {S{1'b0}}};
            r_r_re   <= '0;
            r_r_im   <= '0;
            r_q_re   <= '0;
            r_q_im   <= '0;
            r_ov_re  <= 1'b0;
            r_ov_im  <= 1'b0;
            r_d      <= i_d;
            r_neg_re <= i_m_re[W-1];
            r_neg_im <= ~i_m_im[W-1];
        end else if (r_cnt != '0) begin
            r_n_re  <= r_n_re << 1;
            r_n_im  <= r_n_im << 1;
            r_r_re  <= ge_re ? (t_re - {1'b0, r_d}) : t_re;
            r_r_im  <= ge_im ? (t_im - {1'b0, r_d}) : t_im;
            r_ov_re <= r_ov_re | r_q_re[W-1];
            r_ov_im <= r_ov_im | r_q_im[W-1];
            r_q_re  <= {r_q_re[W-2:0], ge_re};
            r_q_im  <= {r_q_im[W-2:0], ge_im};
        end
        if (r_fin) begin
            r_v_re <= r_neg_re ? -fin_re : fin_re;
            r_v_im <= r_neg_im ? -fin_im : fin_im;
        end
    end

    assign o_done = r_done;
    assign o_v_re = r_v_re;
    assign o_v_im = r_v_im;

endmodule

[hw/rtl/mmfa_dp.sv]
// ----------------------------------------------------------------------------
// mmfa_dp
// Datapath: operand registers, matrix store, shared complex multiplier,
// lane accumulators and the reciprocal unit.
// ----------------------------------------------------------------------------
module mmfa_dp #(
    parameter int W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mmfa_pkg::t_cmd   i_cmd,
    input  mmfa_pkg::t_req   i_req,
    input  mmfa_pkg::t_kind  i_kind,
    output mmfa_pkg::t_sts   o_sts,
    output mmfa_pkg::t_res   o_res,
    output logic             o_valid
);
    localparam int F  = W - 4;
    localparam int WX = 2 * W + 2;
    localparam int WA = W + 2;
    localparam logic signed [WX-1:0] HI_X = {{(WX-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [WX-1:0] LO_X = {{(WX-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [WA-1:0] HI_A = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [WA-1:0] LO_A = {3'b111, {(W-1){1'b0}}};

    typedef struct packed {
        logic       wr_store;
        logic [3:0] st_idx;
        logic       wr_lane;
        logic [1:0] lane;
        logic       first;
    } t_tag;

    logic signed [W-1:0] r_a_re [4];
    logic signed [W-1:0] r_a_im [4];
    logic signed [W-1:0] r_b_re [4];
    logic signed [W-1:0] r_b_im [4];
    logic signed [W-1:0] r_st_re [16];
    logic signed [W-1:0] r_st_im [16];
    logic signed [WA-1:0] r_acc_re [4];
    logic signed [WA-1:0] r_acc_im [4];

    logic r_v1, r_v2, r_valid;
    t_tag r_tag1, r_tag2;
    logic r_conj;
    logic signed [2*W-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [W-1:0]   r_re, r_im;
    logic [2*W-1:0]        r_d;
    mmfa_pkg::t_res        r_res;

    logic signed [W-1:0] x_re, x_im, y_re, y_im;
    logic signed [2*W:0] f_re, f_im;
    logic signed [W-1:0] d_re, d_im;
    logic                div_done;
    logic [3:0]          last;
    logic                sing;
    t_tag                tag0;

    function automatic logic [2*W-1:0] unpack(input logic [31:0] w);
        logic [63:0] t;
        t = {32'd0, w} >> W;
        return {t[W-1:0], w[W-1:0]};
    endfunction

    function automatic logic [31:0] pack(input logic [W-1:0] re, input logic [W-1:0] im);
        logic [63:0] t;
        t = 64'({re, im});
        return t[31:0];
    endfunction

    function automatic logic signed [W-1:0] rnd(input logic signed [2*W:0] x);
        logic signed [WX-1:0] t;
        t = {x[2*W], x} + (WX'(1) << (F - 1));
        t = t >>> F;
        if (t > HI_X) return HI_X[W-1:0];
        if (t < LO_X) return LO_X[W-1:0];
        return t[W-1:0];
    endfunction

    function automatic logic [W-1:0] sat_acc(input logic signed [WA-1:0] x);
        if (x > HI_A) return HI_A[W-1:0];
        if (x < LO_A) return LO_A[W-1:0];
        return x[W-1:0];
    endfunction

    // Operand select: one store read port serves multiply and reciprocal.
    always_comb begin
        if (i_cmd.x_store) begin
            x_re = r_st_re[i_cmd.x_idx];
            x_im = r_st_im[i_cmd.x_idx];
        end else begin
            x_re = r_a_re[i_cmd.x_idx[1:0]];
            x_im = r_a_im[i_cmd.x_idx[1:0]];
        end
        if (i_cmd.y_self) begin
            y_re = x_re;
            y_im = x_im;
        end else if (i_cmd.y_b) begin
            y_re = r_b_re[i_cmd.y_idx];
            y_im = r_b_im[i_cmd.y_idx];
        end else begin
            y_re = r_a_re[i_cmd.y_idx];
            y_im = r_a_im[i_cmd.y_idx];
        end
        tag0.wr_store = i_cmd.wr_store;
        tag0.st_idx   = i_cmd.st_idx;
        tag0.wr_lane  = i_cmd.wr_lane;
        tag0.lane     = i_cmd.lane;
        tag0.first    = i_cmd.first;
    end

    always_comb begin
        if (r_conj) begin
            f_re = {r_p0[2*W-1], r_p0} + {r_p1[2*W-1], r_p1};
            f_im = {r_p3[2*W-1], r_p3} - {r_p2[2*W-1], r_p2};
        end else begin
            f_re = {r_p0[2*W-1], r_p0} - {r_p1[2*W-1], r_p1};
            f_im = {r_p2[2*W-1], r_p2} + {r_p3[2*W-1], r_p3};
        end
    end

    always_comb begin
        last = mmfa_pkg::kind_last(i_kind);
        sing = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (4'(i) <= last && r_st_re[i] == '0 && r_st_im[i] == '0) begin
                sing = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_valid <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                r_st_re[i] <= '0;
                r_st_im[i] <= '0;
            end
        end else begin
            r_v1    <= i_cmd.issue;
            r_v2    <= r_v1;
            r_valid <= i_cmd.finish;
            if (i_cmd.clr) begin
                for (int i = 0; i < 16; i++) begin
                    if (4'(i) <= last) begin
                        r_st_re[i] <= '0;
                        r_st_im[i] <= '0;
                    end
                end
            end
            if (r_v2 && r_tag2.wr_store) begin
                r_st_re[r_tag2.st_idx] <= r_re;
                r_st_im[r_tag2.st_idx] <= r_im;
            end
            if (i_cmd.inv_wr) begin
                r_st_re[{2'b00, i_cmd.inv_idx}] <= d_re;
                r_st_im[{2'b00, i_cmd.inv_idx}] <= d_im;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a_re[0] <= unpack(i_req.op_a0)[2*W-1:W];
            r_a_im[0] <= unpack(i_req.op_a0)[W-1:0];
            r_a_re[1] <= unpack(i_req.op_a1)[2*W-1:W];
            r_a_im[1] <= unpack(i_req.op_a1)[W-1:0];
            r_a_re[2] <= unpack(i_req.op_a2)[2*W-1:W];
            r_a_im[2] <= unpack(i_req.op_a2)[W-1:0];
            r_a_re[3] <= unpack(i_req.op_a3)[2*W-1:W];
            r_a_im[3] <= unpack(i_req.op_a3)[W-1:0];
            r_b_re[0] <= unpack(i_req.op_b0)[2*W-1:W];
            r_b_im[0] <= unpack(i_req.op_b0)[W-1:0];
            r_b_re[1] <= unpack(i_req.op_b1)[2*W-1:W];
            r_b_im[1] <= unpack(i_req.op_b1)[W-1:0];
            r_b_re[2] <= unpack(i_req.op_b2)[2*W-1:W];
            r_b_im[2] <= unpack(i_req.op_b2)[W-1:0];
            r_b_re[3] <= unpack(i_req.op_b3)[2*W-1:W];
            r_b_im[3] <= unpack(i_req.op_b3)[W-1:0];
            for (int i = 0; i < 4; i++) begin
                r_acc_re[i] <= '0;
                r_acc_im[i] <= '0;
            end
        end else if (r_v2 && r_tag2.wr_lane) begin
            if (r_tag2.first) begin
                r_acc_re[r_tag2.lane] <= WA'(r_re);
                r_acc_im[r_tag2.lane] <= WA'(r_im);
            end else begin
                r_acc_re[r_tag2.lane] <= r_acc_re[r_tag2.lane] + WA'(r_re);
                r_acc_im[r_tag2.lane] <= r_acc_im[r_tag2.lane] + WA'(r_im);
            end
        end
        // multiplier stage, then round and saturate stage
        r_p0   <= x_re * y_re;
        r_p1   <= x_im * y_im;
        r_p2   <= x_re * y_im;
        r_p3   <= x_im * y_re;
        r_conj <= i_cmd.conj;
        r_tag1 <= tag0;
        r_re   <= rnd(f_re);
        r_im   <= rnd(f_im);
        r_d    <= f_re[2*W-1:0];
        r_tag2 <= r_tag1;
        if (i_cmd.finish) begin
            r_res.out_v0 <= pack(sat_acc(r_acc_re[0]), sat_acc(r_acc_im[0]));
            r_res.out_v1 <= pack(sat_acc(r_acc_re[1]), sat_acc(r_acc_im[1]));
            r_res.out_v2 <= pack(sat_acc(r_acc_re[2]), sat_acc(r_acc_im[2]));
            r_res.out_v3 <= pack(sat_acc(r_acc_re[3]), sat_acc(r_acc_im[3]));
            r_res.status <= i_cmd.status;
        end
    end

    mmfa_div #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_m_re  (x_re),
        .i_m_im  (x_im),
        .i_d     (r_d),
        .o_done  (div_done),
        .o_v_re  (d_re),
        .o_v_im  (d_im)
    );

    assign o_sts.sing     = sing;
    assign o_sts.div_done = div_done;
    assign o_res          = r_res;
    assign o_valid        = r_valid;

endmodule

[hw/rtl/mmfa_ctrl.sv]
// ----------------------------------------------------------------------------
// mmfa_ctrl
// Controller: sequences form, apply, invert and clear over the datapath.
// ----------------------------------------------------------------------------
module mmfa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  mmfa_pkg::t_req  i_req,
    input  mmfa_pkg::t_kind i_kind,
    input  mmfa_pkg::t_sts  i_sts,
    output mmfa_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    typedef enum logic [3:0] {
        S_IDLE, S_RUN, S_DRAIN, S_CHK, S_MUL, S_WAIT, S_GO, S_DIV, S_WR, S_DONE
    } t_state;

    t_state            r_state, n_state;
    mmfa_pkg::t_op     r_op, n_op;
    logic [2:0]        r_cnt, n_cnt;
    logic [3:0]        r_k, n_k;
    logic              r_drain, n_drain;
    logic [1:0]        r_i, n_i;
    mmfa_pkg::t_status r_status, n_status;
    logic              r_clr, n_clr;
    logic              r_busy, n_busy;

    mmfa_pkg::t_op op_in;
    logic          bad_len;
    logic [3:0]    last;

    always_comb begin
        op_in   = mmfa_pkg::t_op'(i_req.opcode);
        last    = mmfa_pkg::kind_last(i_kind);
        bad_len = !(i_req.vis_count == 3'd1 || i_req.vis_count == 3'd2 ||
                    i_req.vis_count == 3'd4) ||
                  (i_kind == mmfa_pkg::KIND_GENERAL && i_req.vis_count != 3'd4);
    end

    // Next state
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_drain  = r_drain;
        n_i      = r_i;
        n_status = r_status;
        n_clr    = r_clr;
        n_busy   = r_busy;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op     = op_in;
                    n_cnt    = i_req.vis_count;
                    n_k      = '0;
                    n_busy   = 1'b1;
                    n_clr    = 1'b0;
                    n_status = mmfa_pkg::ST_OK;
                    unique case (op_in)
                        mmfa_pkg::OP_FORM: n_state = S_RUN;
                        mmfa_pkg::OP_APPLY: begin
                            if (bad_len) begin
                                n_state  = S_DONE;
                                n_status = mmfa_pkg::ST_MISMATCH;
                            end else begin
                                n_state = S_RUN;
                            end
                        end
                        mmfa_pkg::OP_INVERT: begin
                            if (i_kind == mmfa_pkg::KIND_GENERAL) begin
                                n_state  = S_DONE;
                                n_status = mmfa_pkg::ST_MISMATCH;
                            end else begin
                                n_state = S_CHK;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                            n_clr   = 1'b1;
                        end
                    endcase
                end
            end
            S_RUN: begin
                n_k = r_k + 4'd1;
                if (&r_k) begin
                    n_state = S_DRAIN;
                    n_drain = 1'b0;
                end
            end
            S_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = S_DONE;
                end
            end
            S_CHK: begin
                if (i_sts.sing) begin
                    n_state  = S_DONE;
                    n_status = mmfa_pkg::ST_SINGULAR;
                    n_clr    = 1'b1;
                end else begin
                    n_i     = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_WAIT;
            S_WAIT: n_state = S_GO;
            S_GO:   n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                if ({2'b00, r_i} == last) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.load = (r_state == S_IDLE) && i_start;
        unique case (r_state)
            S_RUN: begin
                if (r_op == mmfa_pkg::OP_FORM) begin
                    o_cmd.conj     = 1'b1;
                    o_cmd.y_b      = 1'b1;
                    o_cmd.wr_store = 1'b1;
                    o_cmd.st_idx   = r_k;
                    unique case (i_kind)
                        mmfa_pkg::KIND_GENERAL: begin
                            o_cmd.issue = 1'b1;
                            o_cmd.x_idx = {2'b00, r_k[3], r_k[1]};
                            o_cmd.y_idx = {r_k[2], r_k[0]};
                        end
                        mmfa_pkg::KIND_DIAG: begin
                            o_cmd.issue = r_k < 4'd4;
                            o_cmd.x_idx = {3'b000, r_k[1]};
                            o_cmd.y_idx = {1'b0, r_k[0]};
                        end
                        mmfa_pkg::KIND_CORNER: begin
                            o_cmd.issue = r_k < 4'd2;
                            o_cmd.x_idx = r_k;
                            o_cmd.y_idx = r_k[1:0];
                        end
                        default: begin
                            o_cmd.issue = r_k == 4'd0;
                        end
                    endcase
                end else begin
                    // apply: x is the matrix entry, y the visibility
                    o_cmd.x_store = 1'b1;
                    o_cmd.wr_lane = 1'b1;
                    o_cmd.first   = 1'b1;
                    unique case (i_kind)
                        mmfa_pkg::KIND_GENERAL: begin
                            o_cmd.issue = 1'b1;
                            o_cmd.x_idx = r_k;
                            o_cmd.y_idx = r_k[1:0];
                            o_cmd.lane  = r_k[3:2];
                            o_cmd.first = r_k[1:0] == 2'd0;
                        end
                        mmfa_pkg::KIND_DIAG: begin
                            if (r_cnt == 3'd4) begin
                                o_cmd.issue = r_k < 4'd4;
                                o_cmd.x_idx = r_k;
                                o_cmd.y_idx = r_k[1:0];
                                o_cmd.lane  = r_k[1:0];
                            end else begin
                                o_cmd.issue = (r_k == 4'd0) ||
                                              (r_k == 4'd1 && r_cnt == 3'd2);
                                o_cmd.x_idx = r_k[0] ? 4'd3 : 4'd0;
                                o_cmd.y_idx = r_k[1:0];
                                o_cmd.lane  = r_k[1:0];
                            end
                        end
                        mmfa_pkg::KIND_CORNER: begin
                            o_cmd.issue = (r_k == 4'd0) ||
                                          (r_k == 4'd1 && r_cnt != 3'd1);
                            o_cmd.x_idx = r_k;
                            if (r_cnt == 3'd4 && r_k[0]) begin
                                o_cmd.y_idx = 2'd3;
                                o_cmd.lane  = 2'd3;
                            end else begin
                                o_cmd.y_idx = r_k[1:0];
                                o_cmd.lane  = r_k[1:0];
                            end
                        end
                        default: begin
                            o_cmd.issue = {1'b0, r_cnt} > r_k;
                            o_cmd.y_idx = r_k[1:0];
                            o_cmd.lane  = r_k[1:0];
                        end
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.issue   = 1'b1;
                o_cmd.x_store = 1'b1;
                o_cmd.x_idx   = {2'b00, r_i};
                o_cmd.y_self  = 1'b1;
                o_cmd.conj    = 1'b1;
            end
            S_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.x_store = 1'b1;
                o_cmd.x_idx   = {2'b00, r_i};
            end
            S_WR: begin
                o_cmd.inv_wr  = 1'b1;
                o_cmd.inv_idx = r_i;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                o_cmd.status = r_status;
                o_cmd.clr    = r_clr;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_k      <= '0;
            r_drain  <= 1'b0;
            r_i      <= '0;
            r_clr    <= 1'b0;
            r_status <= mmfa_pkg::ST_OK;
            r_op     <= mmfa_pkg::OP_FORM;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_k      <= n_k;
            r_drain  <= n_drain;
            r_i      <= n_i;
            r_clr    <= n_clr;
            r_status <= n_status;
            r_op     <= n_op;
            r_cnt    <= n_cnt;
        end
    end

    assign o_busy = r_busy;

endmodule

[hw/rtl/mueller_matrix_form_and_apply_core.sv]
// ----------------------------------------------------------------------------
// mueller_matrix_form_and_apply_core
// Keeps a complex Mueller matrix, forms it from two Jones operands, applies
// it to a visibility vector and inverts diagonal layouts.
// ----------------------------------------------------------------------------
// Usage: raise start with a request while busy is low; the request is taken
// at that edge and busy rises. One result follows every request on o_res,
// marked by o_valid for exactly one cycle; the result cannot be held off, so
// capture it when o_valid is high. Form and apply run a fixed 16-step pass
// over one shared complex multiplier (four products, then round and saturate,
// then accumulate). Clear, a rejected apply and a general invert go
// straight to the result; an invert that finds a zero entry ends after that
// check. Otherwise invert runs the bit-serial reciprocal unit once per entry
// of the kind.
// A new request can be taken in the cycle that the result is shown. Write
// matrix_kind through i_cfg_we / i_cfg_wdata only while busy is low.
// ----------------------------------------------------------------------------
module mueller_matrix_form_and_apply_core #(
    parameter int COMP_WIDTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  mmfa_pkg::t_req i_req,
    output logic           busy,
    output logic           o_valid,
    output mmfa_pkg::t_res o_res,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_wdata
);
    mmfa_pkg::t_kind r_kind;
    mmfa_pkg::t_cmd  cmd;
    mmfa_pkg::t_sts  sts;

    // Hold the matrix layout; the store is reread in the new layout.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= mmfa_pkg::KIND_GENERAL;
        end else if (i_cfg_we) begin
            r_kind <= mmfa_pkg::t_kind'(i_cfg_wdata);
        end
    end

    mmfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .i_kind  (r_kind),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    mmfa_dp #(.W(COMP_WIDTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .i_kind  (r_kind),
        .o_sts   (sts),
        .o_res   (o_res),
        .o_valid (o_valid)
    );

`ifndef SYNTHESIS
    // A result only ends a busy request.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a request in flight");

    a_busy_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request taken but busy not raised");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res.status == mmfa_pkg::ST_OK ||
                    o_res.status == mmfa_pkg::ST_SINGULAR ||
                    o_res.status == mmfa_pkg::ST_MISMATCH)
        else $error("unknown status code");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.status != mmfa_pkg::ST_OK |->
            o_res.out_v0 == '0 && o_res.out_v1 == '0 &&
            o_res.out_v2 == '0 && o_res.out_v3 == '0)
        else $error("nonzero visibilities with an error status");
`endif

endmodule
